// ----- rtl/core/banded_lu_linear_solver_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the banded LU solver
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BANDED_LU_LINEAR_SOLVER_DEFINES_SVH
`define BANDED_LU_LINEAR_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define BLU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed")
`define BLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed")
`else
`define BLU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BLU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/blu_pkg.sv -----
// ----------------------------------------------------------------------------
// Banded LU solver package
// Shared types and codes of the solver and its arithmetic units.
// ----------------------------------------------------------------------------
package blu_pkg;
   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 40;

   localparam logic [2:0] K_LOWER = 3'd0;
   localparam logic [2:0] K_UPPER = 3'd1;
   localparam logic [2:0] K_DIAG  = 3'd2;
   localparam logic [2:0] K_RHS   = 3'd3;
   localparam logic [2:0] K_SOLVE = 3'd4;
   localparam logic [2:0] K_READ  = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PIVOT = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic RK_STATUS = 1'b0;
   localparam logic RK_READ   = 1'b1;

   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_HBW   = 1'b1;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] num;
      logic signed [DATA_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic                     sat;
      logic                     zero;
      logic signed [DATA_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
      logic acc_sel;
   } mac_ctl_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] val;
   } sat_type;
endpackage

// ----- rtl/core/blu_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One registered 32x32 product, floored to the fixed-point grid and added
// into one of two accumulators.
// ----------------------------------------------------------------------------
module blu_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  blu_pkg::mac_ctl_type              ctl,
   input  logic signed [blu_pkg::DATA_W-1:0] op_a,
   input  logic signed [blu_pkg::DATA_W-1:0] op_b,
   output logic signed [blu_pkg::ACC_W-1:0]  acc_l,
   output logic signed [blu_pkg::ACC_W-1:0]  acc_u
);
   import blu_pkg::*;

   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_l_ff;
   logic signed [ACC_W-1:0] acc_u_ff;
   logic signed [ACC_W-1:0] term;

   // Arithmetic shift rounds toward minus infinity.
   assign term = prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= ACC_W'(op_a) * ACC_W'(op_b);
      end
      if (ctl.clear) begin
         acc_l_ff <= '0;
         acc_u_ff <= '0;
      end else if (ctl.acc_en) begin
         if (ctl.acc_sel) begin
            acc_u_ff <= acc_u_ff + term;
         end else begin
            acc_l_ff <= acc_l_ff + term;
         end
      end
   end

   assign acc_l = acc_l_ff;
   assign acc_u = acc_u_ff;
endmodule

// ----- rtl/core/blu_div.sv -----
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring division, one quotient bit a cycle, of num * 2^FRAC_BITS by den,
// truncated toward zero and saturated to 32 signed bits.
// ----------------------------------------------------------------------------
module blu_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  blu_pkg::div_req_type req,
   output blu_pkg::div_rsp_type rsp
);
   import blu_pkg::*;

   localparam int DW = DATA_W + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_type;

   dstate_type               state_ff;
   logic [DW-1:0]            dvd_ff;
   logic [DATA_W-1:0]        dvs_ff;
   logic [DATA_W:0]          rem_ff;
   logic [CW-1:0]            cnt_ff;
   logic                     neg_ff;
   logic                     done_ff;
   logic                     sat_ff;
   logic                     zero_ff;
   logic signed [DATA_W-1:0] quot_ff;

   logic [DATA_W:0]   rem_sh;
   logic              ge;
   logic [DATA_W:0]   rem_in;
   logic              pos_ovf;
   logic              neg_ovf;
   logic [DATA_W-1:0] num_mag;
   logic [DATA_W-1:0] den_mag;

   assign num_mag = req.num[DATA_W-1] ? (~req.num + 1'b1) : req.num;
   assign den_mag = req.den[DATA_W-1] ? (~req.den + 1'b1) : req.den;
   assign rem_sh  = {rem_ff[DATA_W-1:0], dvd_ff[DW-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_in  = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
   assign pos_ovf = |dvd_ff[DW-1:DATA_W-1];
   assign neg_ovf = (|dvd_ff[DW-1:DATA_W]) ||
                    (dvd_ff[DATA_W-1] && (|dvd_ff[DATA_W-2:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  if (req.den == '0) begin
                     done_ff <= 1'b1;
                     zero_ff <= 1'b1;
                     sat_ff  <= 1'b0;
                     quot_ff <= '0;
                  end else begin
                     neg_ff   <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
                     dvd_ff   <= {num_mag, {FRAC_BITS{1'b0}}};
                     dvs_ff   <= den_mag;
                     rem_ff   <= '0;
                     cnt_ff   <= CW'(DW);
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff <= rem_in;
               dvd_ff <= {dvd_ff[DW-2:0], ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= D_FIX;
               end
            end
            D_FIX: begin
               done_ff  <= 1'b1;
               zero_ff  <= 1'b0;
               state_ff <= D_IDLE;
               if (neg_ff) begin
                  sat_ff  <= neg_ovf;
                  quot_ff <= neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : (~dvd_ff[DATA_W-1:0] + 1'b1);
               end else begin
                  sat_ff  <= pos_ovf;
                  quot_ff <= pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : dvd_ff[DATA_W-1:0];
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.busy = (state_ff != D_IDLE);
   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign rsp.zero = zero_ff;
   assign rsp.quot = quot_ff;
endmodule

// ----- rtl/core/banded_lu_linear_solver.sv -----
// ----------------------------------------------------------------------------
// Banded LU linear solver
// Loads a banded system, factors it in place and solves it by substitution.
// ----------------------------------------------------------------------------
// The request stream carries one item per transfer: tuser holds the kind and
// tdata the row, the band position and a signed Q16.16 value. Lower, upper,
// diagonal and right-hand-side loads give no response. A solve item runs the
// whole factorisation and both substitutions on one shared
// multiply-accumulate unit and one bit-serial divider, then sends a status
// response. A read item sends one solution entry. A solve does about order
// times band squared multiply-accumulates for the band walk and one division
// per lower-band entry of the factor and one per unknown (about order times
// (band + 1)); most of a solve's time goes to the divider.
// The request side is not ready while a read or a solve is in progress.
// The response sits in an output register; if the receiver stalls, the block
// holds it and finishes its next item only once that register is free.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle. Reset clears the control state, the configuration to
// order 32 and half band 4, and the stored status; the stores are not cleared.
// ----------------------------------------------------------------------------
`include "banded_lu_linear_solver_defines.svh"
module banded_lu_linear_solver #(
   parameter int MAX_ORDER     = 32,
   parameter int MAX_HALF_BAND = 4,
   parameter int FRAC_BITS     = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [4:0] row, [6:5] band_pos, [38:7] value, [39] zero
   input  logic [blu_pkg::REQ_W-1:0]   req_tdata,
   // [2:0] kind
   input  logic [2:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] solution, [33:32] status, [39:34] zero
   output logic [blu_pkg::RSP_W-1:0]   rsp_tdata,
   // [0] result_kind
   output logic [0:0]                  rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [7:0]                  csr_data
);
   import blu_pkg::*;

   localparam int ORD_AW  = $clog2(MAX_ORDER);
   localparam int BAND_N  = MAX_ORDER * MAX_HALF_BAND;
   localparam int BAND_AW = $clog2(BAND_N);
   localparam int CNT_W   = $clog2(MAX_ORDER + 1);
   localparam int HB_W    = $clog2(MAX_HALF_BAND + 1);
   localparam int IW      = CNT_W + HB_W + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_ROW_INIT, S_J_INIT, S_MAC_RD, S_MAC_MUL, S_MAC_ACC,
      S_LU_RD, S_LU_SUB, S_LU_DIV, S_D_INIT, S_D_RD, S_D_WR, S_F0_RD, S_F0_WR,
      S_F_ROW, S_F_RD, S_F_WR, S_B_ROW, S_B_RD, S_B_SUB, S_B_DIV, S_DONE
   } state_type;

   // What the shared multiply-accumulate is currently summing.
   typedef enum logic [2:0] {M_L, M_U, M_D, M_F, M_B} mode_type;

   state_type            state_ff;
   mode_type             mode_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [HB_W-1:0]      j_ff;
   logic [HB_W-1:0]      t_ff;
   logic [HB_W-1:0]      m_ff;
   logic [HB_W-1:0]      s_ff;
   logic                 flag_sat_ff;
   logic                 flag_piv_ff;
   logic [1:0]           sticky_ff;
   logic [5:0]           order_ff;
   logic [2:0]           hbw_ff;
   logic                 rd_ok_ff;
   logic [ORD_AW-1:0]    rd_row_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [DATA_W-1:0]    rsp_sol_ff;
   logic [1:0]           rsp_st_ff;

   logic [DATA_W-1:0] lower_mem_ff [BAND_N];
   logic [DATA_W-1:0] upper_mem_ff [BAND_N];
   logic [DATA_W-1:0] diag_mem_ff  [MAX_ORDER];
   logic [DATA_W-1:0] rhs_mem_ff   [MAX_ORDER];
   logic [DATA_W-1:0] work_mem_ff  [MAX_ORDER];
   logic [DATA_W-1:0] sol_mem_ff   [MAX_ORDER];
   logic signed [DATA_W-1:0] lq_ff, uq_ff, dq_ff, rq_ff, wq_ff, xq_ff;

   logic                lo_we, up_we, dg_we, rh_we, wk_we, sl_we;
   logic [BAND_AW-1:0]  lo_wa, up_wa, lo_ra, up_ra;
   logic [ORD_AW-1:0]   dg_wa, rh_wa, wk_wa, sl_wa, dg_ra, rh_ra, wk_ra, sl_ra;
   logic [DATA_W-1:0]   lo_wd, up_wd, dg_wd, rh_wd, wk_wd, sl_wd;

   logic [2:0]          kind;
   logic [4:0]          row;
   logic [1:0]          pos;
   logic [DATA_W-1:0]   value;
   logic                accept;
   logic                row_ok;
   logic                pos_ok;
   logic                out_free;
   logic [IW-1:0]       n_x, h_x, ix, jx, tx, mx, c_x, tb_x, cb_x, hm_x, s_x;
   logic [1:0]          status_now;

   div_req_type              div_req;
   div_rsp_type              div_rsp;
   mac_ctl_type              mac_ctl;
   logic signed [DATA_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0]  acc_l, acc_u;
   sat_type                  sat_lo, sat_up, sat_dg, sat_wk, sat_bk;

   function automatic sat_type sat_sub(input logic signed [DATA_W-1:0] x,
                                       input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] d;
      sat_type                 r;
      d = ACC_W'(x) - acc;
      r.ovf = (d[ACC_W-1:DATA_W-1] != '0) && (d[ACC_W-1:DATA_W-1] != '1);
      if (!r.ovf) begin
         r.val = d[DATA_W-1:0];
      end else if (d[ACC_W-1]) begin
         r.val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.val = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [BAND_AW-1:0] baddr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] p);
      return BAND_AW'(r * MAX_HALF_BAND + p);
   endfunction

   // Request fields and the effective matrix size.
   assign kind     = req_tuser;
   assign row      = req_tdata[4:0];
   assign pos      = req_tdata[6:5];
   assign value    = req_tdata[38:7];
   assign accept   = req_tvalid && req_tready;
   assign row_ok   = {27'b0, row} < 32'(MAX_ORDER);
   assign pos_ok   = {30'b0, pos} < 32'(MAX_HALF_BAND);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if ({26'b0, order_ff} > 32'(MAX_ORDER)) begin
         n_x = IW'(MAX_ORDER);
      end else if (order_ff < 6'd2) begin
         n_x = IW'(2);
      end else begin
         n_x = IW'(order_ff);
      end
      if ({29'b0, hbw_ff} > 32'(MAX_HALF_BAND)) begin
         h_x = IW'(MAX_HALF_BAND);
      end else if (hbw_ff == 3'd0) begin
         h_x = IW'(1);
      end else begin
         h_x = IW'(hbw_ff);
      end
   end

   // Loop indices: c is the column i-h+j, tb the band slot t-j+h, cb the row
   // i+m below the diagonal and hm its slot h-m. Rows near the top skip the
   // band slots that fall left of the matrix and start from slot s.
   assign ix   = IW'(i_ff);
   assign jx   = IW'(j_ff);
   assign tx   = IW'(t_ff);
   assign mx   = IW'(m_ff);
   assign c_x  = ix + jx - h_x;
   assign tb_x = tx + h_x - jx;
   assign cb_x = ix + mx;
   assign hm_x = h_x - mx;
   assign s_x  = (h_x > ix) ? (h_x - ix) : '0;

   assign sat_lo = sat_sub(lq_ff, acc_l);
   assign sat_up = sat_sub(uq_ff, acc_u);
   assign sat_dg = sat_sub(dq_ff, acc_l);
   assign sat_wk = sat_sub(rq_ff, acc_l);
   assign sat_bk = sat_sub(wq_ff, acc_l);

   // Zero pivot outranks saturation.
   assign status_now = flag_piv_ff ? ST_PIVOT : (flag_sat_ff ? ST_SAT : ST_OK);

   // Store ports and unit controls, decoded from the sequencer state.
   always_comb begin
      lo_we = 1'b0;  up_we = 1'b0;  dg_we = 1'b0;
      rh_we = 1'b0;  wk_we = 1'b0;  sl_we = 1'b0;
      lo_wa = '0;    up_wa = '0;    dg_wa = '0;
      rh_wa = '0;    wk_wa = '0;    sl_wa = '0;
      lo_wd = value; up_wd = value; dg_wd = value;
      rh_wd = value; wk_wd = '0;    sl_wd = div_rsp.quot;
      lo_ra = '0;    up_ra = '0;    dg_ra = '0;
      rh_ra = '0;    wk_ra = '0;    sl_ra = rd_row_ff;
      div_req = '0;
      mac_ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            lo_wa = baddr(IW'(row), IW'(pos));
            up_wa = baddr(IW'(row), IW'(pos));
            dg_wa = ORD_AW'(row);
            rh_wa = ORD_AW'(row);
            sl_ra = ORD_AW'(row);
            lo_we = accept && (kind == K_LOWER) && row_ok && pos_ok;
            up_we = accept && (kind == K_UPPER) && row_ok && pos_ok;
            dg_we = accept && (kind == K_DIAG) && row_ok;
            rh_we = accept && (kind == K_RHS) && row_ok;
         end
         S_J_INIT, S_D_INIT, S_F_ROW, S_B_ROW: begin
            mac_ctl.clear = 1'b1;
         end
         S_MAC_RD: begin
            unique case (mode_ff)
               M_L: begin
                  lo_ra = baddr(ix, tx);
                  up_ra = baddr(c_x, tb_x);
               end
               M_U: begin
                  lo_ra = baddr(c_x, tb_x);
                  up_ra = baddr(ix, tx);
               end
               M_D: begin
                  lo_ra = baddr(ix, jx);
                  up_ra = baddr(ix, jx);
               end
               M_F: begin
                  lo_ra = baddr(ix, jx);
                  wk_ra = c_x[ORD_AW-1:0];
               end
               M_B: begin
                  up_ra = baddr(cb_x, hm_x);
                  sl_ra = cb_x[ORD_AW-1:0];
               end
               default: begin
                  lo_ra = '0;
               end
            endcase
         end
         S_MAC_MUL: mac_ctl.mul_en = 1'b1;
         S_MAC_ACC: begin
            mac_ctl.acc_en  = 1'b1;
            mac_ctl.acc_sel = (mode_ff == M_U);
         end
         S_LU_RD: begin
            lo_ra = baddr(ix, jx);
            up_ra = baddr(ix, jx);
            dg_ra = c_x[ORD_AW-1:0];
         end
         S_LU_SUB: begin
            up_we         = 1'b1;
            up_wa         = baddr(ix, jx);
            up_wd         = sat_up.val;
            div_req.start = 1'b1;
            div_req.num   = sat_lo.val;
            div_req.den   = dq_ff;
         end
         S_LU_DIV: begin
            lo_we = div_rsp.done;
            lo_wa = baddr(ix, jx);
            lo_wd = div_rsp.quot;
         end
         S_D_RD: dg_ra = ix[ORD_AW-1:0];
         S_D_WR: begin
            dg_we = 1'b1;
            dg_wa = ix[ORD_AW-1:0];
            dg_wd = sat_dg.val;
         end
         S_F0_RD: rh_ra = '0;
         S_F0_WR: begin
            wk_we = 1'b1;
            wk_wa = '0;
            wk_wd = rq_ff;
         end
         S_F_RD: rh_ra = ix[ORD_AW-1:0];
         S_F_WR: begin
            wk_we = 1'b1;
            wk_wa = ix[ORD_AW-1:0];
            wk_wd = sat_wk.val;
         end
         S_B_RD: begin
            wk_ra = ix[ORD_AW-1:0];
            dg_ra = ix[ORD_AW-1:0];
         end
         S_B_SUB: begin
            div_req.start = 1'b1;
            div_req.num   = sat_bk.val;
            div_req.den   = dq_ff;
         end
         S_B_DIV: begin
            sl_we = div_rsp.done;
            sl_wa = ix[ORD_AW-1:0];
         end
         default: begin
            lo_ra = '0;
         end
      endcase
   end

   // Operands of the shared multiplier for each kind of sum.
   always_comb begin
      unique case (mode_ff)
         M_F: begin
            op_a = lq_ff;
            op_b = wq_ff;
         end
         M_B: begin
            op_a = uq_ff;
            op_b = xq_ff;
         end
         default: begin
            op_a = lq_ff;
            op_b = uq_ff;
         end
      endcase
   end

   // Stores, each with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (lo_we) lower_mem_ff[lo_wa] <= lo_wd;
      lq_ff <= lower_mem_ff[lo_ra];
   end
   always_ff @(posedge clock) begin
      if (up_we) upper_mem_ff[up_wa] <= up_wd;
      uq_ff <= upper_mem_ff[up_ra];
   end
   always_ff @(posedge clock) begin
      if (dg_we) diag_mem_ff[dg_wa] <= dg_wd;
      dq_ff <= diag_mem_ff[dg_ra];
   end
   always_ff @(posedge clock) begin
      if (rh_we) rhs_mem_ff[rh_wa] <= rh_wd;
      rq_ff <= rhs_mem_ff[rh_ra];
   end
   always_ff @(posedge clock) begin
      if (wk_we) work_mem_ff[wk_wa] <= wk_wd;
      wq_ff <= work_mem_ff[wk_ra];
   end
   always_ff @(posedge clock) begin
      if (sl_we) sol_mem_ff[sl_wa] <= sl_wd;
      xq_ff <= sol_mem_ff[sl_ra];
   end

   blu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc_l (acc_l),
      .acc_u (acc_u)
   );

   blu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 6'd32;
         hbw_ff   <= 3'd4;
      end else if (csr_valid) begin
         unique case (csr_index[0])
            CSR_ORDER: order_ff <= csr_data[5:0];
            CSR_HBW:   hbw_ff   <= csr_data[2:0];
            default:   order_ff <= order_ff;
         endcase
      end
   end

   // Sequencer: factorisation row by row, forward sweep, backward sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_L;
         sticky_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
         flag_sat_ff  <= 1'b0;
         flag_piv_ff  <= 1'b0;
      end else begin
         // The read and done states load the next response themselves.
         if (rsp_valid_ff && rsp_tready &&
             !((state_ff == S_READ) || (state_ff == S_DONE))) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (kind == K_SOLVE)) begin
                  flag_sat_ff <= 1'b0;
                  flag_piv_ff <= 1'b0;
                  i_ff        <= CNT_W'(1);
                  state_ff    <= S_ROW_INIT;
               end else if (accept && (kind == K_READ)) begin
                  rd_ok_ff  <= row_ok;
                  rd_row_ff <= ORD_AW'(row);
                  state_ff  <= S_READ;
               end
            end
            S_READ: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= RK_READ;
                  rsp_sol_ff   <= rd_ok_ff ? xq_ff : '0;
                  rsp_st_ff    <= sticky_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_ROW_INIT: begin
               s_ff     <= HB_W'(s_x);
               j_ff     <= HB_W'(s_x);
               state_ff <= S_J_INIT;
            end
            S_J_INIT: begin
               t_ff <= s_ff;
               if (s_ff < j_ff) begin
                  mode_ff  <= M_L;
                  state_ff <= S_MAC_RD;
               end else begin
                  state_ff <= S_LU_RD;
               end
            end
            S_MAC_RD:  state_ff <= S_MAC_MUL;
            S_MAC_MUL: state_ff <= S_MAC_ACC;
            S_MAC_ACC: begin
               unique case (mode_ff)
                  M_L: begin
                     mode_ff  <= M_U;
                     state_ff <= S_MAC_RD;
                  end
                  M_U: begin
                     t_ff    <= t_ff + 1'b1;
                     mode_ff <= M_L;
                     state_ff <= (tx + 1'b1 < jx) ? S_MAC_RD : S_LU_RD;
                  end
                  M_D, M_F: begin
                     if (jx + 1'b1 < h_x) begin
                        j_ff     <= j_ff + 1'b1;
                        state_ff <= S_MAC_RD;
                     end else begin
                        state_ff <= (mode_ff == M_D) ? S_D_RD : S_F_RD;
                     end
                  end
                  M_B: begin
                     m_ff <= m_ff + 1'b1;
                     if ((mx + 1'b1 <= h_x) && (cb_x + 1'b1 < n_x)) begin
                        state_ff <= S_MAC_RD;
                     end else begin
                        state_ff <= S_B_RD;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_LU_RD: state_ff <= S_LU_SUB;
            S_LU_SUB: begin
               if (sat_lo.ovf || sat_up.ovf) flag_sat_ff <= 1'b1;
               state_ff <= S_LU_DIV;
            end
            S_LU_DIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.sat)  flag_sat_ff <= 1'b1;
                  if (div_rsp.zero) flag_piv_ff <= 1'b1;
                  if (jx + 1'b1 < h_x) begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_J_INIT;
                  end else begin
                     state_ff <= S_D_INIT;
                  end
               end
            end
            S_D_INIT: begin
               j_ff     <= s_ff;
               mode_ff  <= M_D;
               state_ff <= S_MAC_RD;
            end
            S_D_RD: state_ff <= S_D_WR;
            S_D_WR: begin
               if (sat_dg.ovf) flag_sat_ff <= 1'b1;
               if (ix + 1'b1 < n_x) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_ROW_INIT;
               end else begin
                  state_ff <= S_F0_RD;
               end
            end
            S_F0_RD: state_ff <= S_F0_WR;
            S_F0_WR: begin
               i_ff     <= CNT_W'(1);
               state_ff <= S_F_ROW;
            end
            S_F_ROW: begin
               j_ff     <= HB_W'(s_x);
               mode_ff  <= M_F;
               state_ff <= S_MAC_RD;
            end
            S_F_RD: state_ff <= S_F_WR;
            S_F_WR: begin
               if (sat_wk.ovf) flag_sat_ff <= 1'b1;
               if (ix + 1'b1 < n_x) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_F_ROW;
               end else begin
                  i_ff     <= CNT_W'(n_x - 1'b1);
                  state_ff <= S_B_ROW;
               end
            end
            S_B_ROW: begin
               m_ff     <= HB_W'(1);
               mode_ff  <= M_B;
               state_ff <= (ix + 1'b1 < n_x) ? S_MAC_RD : S_B_RD;
            end
            S_B_RD: state_ff <= S_B_SUB;
            S_B_SUB: begin
               if (sat_bk.ovf) flag_sat_ff <= 1'b1;
               state_ff <= S_B_DIV;
            end
            S_B_DIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.sat)  flag_sat_ff <= 1'b1;
                  if (div_rsp.zero) flag_piv_ff <= 1'b1;
                  if (i_ff == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     i_ff     <= i_ff - 1'b1;
                     state_ff <= S_B_ROW;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  sticky_ff    <= status_now;
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= RK_STATUS;
                  rsp_sol_ff   <= '0;
                  rsp_st_ff    <= status_now;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(RSP_W-DATA_W-2){1'b0}}, rsp_st_ff, rsp_sol_ff};
   assign rsp_tuser[0] = rsp_kind_ff;

   `BLU_ASSERT_IMPL(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy);
   `BLU_ASSERT_NEXT(a_solve_blocks, clock, reset, accept && (kind == K_SOLVE), !req_tready);
   `BLU_ASSERT_IMPL(a_sticky_code, clock, reset, 1'b1, sticky_ff <= ST_SAT);
   `BLU_ASSERT_IMPL(a_mac_range, clock, reset, (state_ff == S_MAC_RD) && (mode_ff == M_L), t_ff < j_ff);
endmodule
